@@ rtl/blf_pkg.sv @@
// ----------------------------------------------------------------------------
// blf_pkg
// Shared constants and types of the binary 3x3 lookup filter.
// ----------------------------------------------------------------------------
package blf_pkg;

  // Default frame limits
  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;

  // Lookup table: 512 one-bit entries held in eight 64-bit words
  localparam int TABLE_WORDS   = 8;
  localparam int TABLE_WORD_W  = 64;
  localparam int TABLE_SEL_W   = 3;
  localparam int TABLE_BIT_W   = 6;
  localparam int LUT_INDEX_W   = TABLE_SEL_W + TABLE_BIT_W;

  // Configuration port
  localparam int CFG_INDEX_W   = 4;
  localparam logic [CFG_INDEX_W-1:0] REG_TABLE_WORD_0 = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_TABLE_WORD_7 = 4'd7;

  // Stream widths and coordinate width
  localparam int COORD_W       = 8;
  localparam int IN_TDATA_W    = 8;
  localparam int OUT_TDATA_W   = 24;

  // Window shift control: one column triple {top, middle, bottom}
  typedef struct packed {
    logic       shift;
    logic [2:0] col;
  } win_in_t;

endpackage

@@ rtl/blf_line_store.sv @@
// ----------------------------------------------------------------------------
// blf_line_store
// Two line stores in one memory: bit 1 is the older row, bit 0 the newer.
// Registered read with forwarding of a same-address write.
// ----------------------------------------------------------------------------
module blf_line_store #(
  parameter int MAX_WIDTH = blf_pkg::DEF_MAX_WIDTH,
  parameter int AW        = $clog2(MAX_WIDTH)
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [1:0]    wr_data,
  output logic [1:0]    rd_data
);

  logic [1:0] mem [MAX_WIDTH];
  logic [1:0] mem_q;
  logic       fwd_hit;
  logic [1:0] fwd_data;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  // Capture a write that lands on the address being read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_hit  <= wr_en && (wr_addr == rd_addr);
      fwd_data <= wr_data;
    end
  end

  assign rd_data = fwd_hit ? fwd_data : mem_q;

endmodule

@@ rtl/blf_table.sv @@
// ----------------------------------------------------------------------------
// blf_table
// Lookup table registers written over the config port, one-bit lookup.
// ----------------------------------------------------------------------------
module blf_table (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wr,
  input  logic [blf_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [blf_pkg::TABLE_WORD_W-1:0]     cfg_data,
  input  logic [blf_pkg::LUT_INDEX_W-1:0]      lut_index,
  output logic                                 lut_bit
);

  logic [blf_pkg::TABLE_WORD_W-1:0] table_word [blf_pkg::TABLE_WORDS];

  // Write a table word; drop writes beyond the last word
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < blf_pkg::TABLE_WORDS; i++) begin
        table_word[i] <= '0;
      end
    end else if (cfg_wr && cfg_index <= blf_pkg::REG_TABLE_WORD_7) begin
      table_word[cfg_index[blf_pkg::TABLE_SEL_W-1:0]] <= cfg_data;
    end
  end

  // Select word by the high index bits, bit by the low ones
  assign lut_bit = table_word[lut_index[blf_pkg::LUT_INDEX_W-1:blf_pkg::TABLE_BIT_W]]
                             [lut_index[blf_pkg::TABLE_BIT_W-1:0]];

endmodule

@@ rtl/blf_window.sv @@
// ----------------------------------------------------------------------------
// blf_window
// Holds the two previous column triples and forms the 9-bit window index.
// ----------------------------------------------------------------------------
module blf_window (
  input  logic                            clk,
  input  logic                            rst,
  input  blf_pkg::win_in_t                win_in,
  output logic [blf_pkg::LUT_INDEX_W-1:0] lut_index
);

  logic [5:0] window_bits;
  logic [2:0] col_a;
  logic [2:0] col_b;

  // Shift in the current column triple
  always_ff @(posedge clk) begin
    if (rst) begin
      window_bits <= '0;
    end else if (win_in.shift) begin
      window_bits <= {window_bits[2:0], win_in.col};
    end
  end

  // Column c-2 is col_a, column c-1 is col_b; top-left lands in bit 8
  assign col_a = window_bits[5:3];
  assign col_b = window_bits[2:0];
  assign lut_index = {col_a[2], col_b[2], win_in.col[2],
                      col_a[1], col_b[1], win_in.col[1],
                      col_a[0], col_b[0], win_in.col[0]};

endmodule

@@ rtl/binary_3x3_lut_filter.sv @@
// ----------------------------------------------------------------------------
// binary_3x3_lut_filter
// Path: an accepted pixel and its line store read are registered in stage 1,
// then window and table select feed the output register.
// Throughput: one pixel per cycle while the output is not stalled; the registered
// line store read sets the two-stage depth.
// Reset: counters, window and table words clear; line stores are not cleared.
// ----------------------------------------------------------------------------
module binary_3x3_lut_filter #(
  parameter int MAX_WIDTH  = blf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = blf_pkg::DEF_MAX_HEIGHT
) (
  input  logic                               clk,
  input  logic                               rst,
  // Input pixel stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [blf_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // [0] pixel_in
  input  logic                               s_axis_tlast,  // frame_end
  input  logic                               s_axis_tuser,  // row_end
  // Output pixel stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [blf_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // [0] pixel_out,
                                                            // [8:1] out_row,
                                                            // [16:9] out_col
  output logic                               m_axis_tlast,  // frame_last
  // Configuration write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [blf_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [blf_pkg::TABLE_WORD_W-1:0]   cfg_data
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 1);

  logic          in_accept;
  logic [CW-1:0] column_count;
  logic [RW-1:0] row_count;

  logic          s1_valid;
  logic          s1_pix;
  logic          s1_fend;
  logic          s1_inrange;
  logic [CW-1:0] s1_col;
  logic [RW-1:0] s1_row;
  logic          s1_emit;
  logic          s1_advance;

  logic [1:0]    store_rd;
  logic          store_wr;
  logic [blf_pkg::LUT_INDEX_W-1:0] lut_index;
  logic          lut_bit;
  blf_pkg::win_in_t win_in;

  logic [RW+blf_pkg::COORD_W-1:0] row_ext;
  logic [CW+blf_pkg::COORD_W-1:0] col_ext;

  logic                        out_valid;
  logic                        out_pix;
  logic [blf_pkg::COORD_W-1:0] out_row;
  logic [blf_pkg::COORD_W-1:0] out_col;
  logic                        out_last;

  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !s1_valid || s1_advance;
  assign cfg_ready     = 1'b1;

  // Advance column and row counters on each accepted pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (in_accept) begin
      if (s_axis_tlast) begin
        column_count <= '0;
        row_count    <= '0;
      end else if (s_axis_tuser) begin
        column_count <= '0;
        if (row_count < RW'(MAX_HEIGHT)) begin
          row_count <= row_count + RW'(1);
        end
      end else if (column_count < CW'(MAX_WIDTH)) begin
        column_count <= column_count + CW'(1);
      end
    end
  end

  // Stage 1 valid: load on accept, drop when it moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  // Stage 1 payload, aligned with the line store read data
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_pix     <= s_axis_tdata[0];
      s1_fend    <= s_axis_tlast;
      s1_col     <= column_count;
      s1_row     <= row_count;
      s1_inrange <= (column_count < CW'(MAX_WIDTH)) && (row_count < RW'(MAX_HEIGHT));
    end
  end

  assign s1_emit    = s1_inrange && (s1_row >= RW'(2)) && (s1_col >= CW'(2));
  assign s1_advance = s1_valid && (!s1_emit || !out_valid || m_axis_tready);
  assign store_wr   = s1_advance && s1_inrange;

  blf_line_store #(
    .MAX_WIDTH (MAX_WIDTH),
    .AW        (AW)
  ) u_line_store (
    .clk     (clk),
    .rd_en   (in_accept),
    .rd_addr (column_count[AW-1:0]),
    .wr_en   (store_wr),
    .wr_addr (s1_col[AW-1:0]),
    .wr_data ({store_rd[0], s1_pix}),
    .rd_data (store_rd)
  );

  // Current column triple {top, middle, bottom}
  assign win_in.shift = store_wr;
  assign win_in.col   = {store_rd[1], store_rd[0], s1_pix};

  blf_window u_window (
    .clk       (clk),
    .rst       (rst),
    .win_in    (win_in),
    .lut_index (lut_index)
  );

  blf_table u_table (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .lut_index (lut_index),
    .lut_bit   (lut_bit)
  );

  // Coordinates of the window center, low bits kept
  assign row_ext = {{blf_pkg::COORD_W{1'b0}}, s1_row} - (RW + blf_pkg::COORD_W)'(1);
  assign col_ext = {{blf_pkg::COORD_W{1'b0}}, s1_col} - (CW + blf_pkg::COORD_W)'(1);

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance && s1_emit) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (s1_advance && s1_emit) begin
      out_pix  <= lut_bit;
      out_row  <= row_ext[blf_pkg::COORD_W-1:0];
      out_col  <= col_ext[blf_pkg::COORD_W-1:0];
      out_last <= s1_fend;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'd0, out_col, out_row, out_pix};
  assign m_axis_tlast  = out_last;

  // An empty stage 1 always takes a pixel
  assert property (@(posedge clk) disable iff (rst) !s1_valid |-> s_axis_tready)
    else $error("input stalled with stage 1 empty");

  // A frame-end pixel returns both counters to zero
  assert property (@(posedge clk) disable iff (rst)
    in_accept && s_axis_tlast |=> column_count == '0 && row_count == '0)
    else $error("counters not cleared after frame end");

  // Counters never pass the frame limits
  assert property (@(posedge clk) disable iff (rst)
    column_count <= CW'(MAX_WIDTH) && row_count <= RW'(MAX_HEIGHT))
    else $error("counter beyond frame limit");

  // A result waiting on a stalled output holds stage 1
  assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_emit && out_valid && !m_axis_tready |=> s1_valid)
    else $error("stage 1 lost a pending result");

endmodule
